// ----- rtl/qrs_pkg.sv -----
// shared types and constants for the ray quadratic root select block
// no dependencies
package qrs_pkg;

    localparam int QRS_FRAC_BITS = 16;
    localparam int QRS_ADDR_W    = 3;
    localparam int QRS_TMIN_W    = 31;
    localparam int QRS_DISC_W    = 66;
    localparam int QRS_ROOT_W    = 33;
    localparam int QRS_REM_W     = 34;
    localparam int QRS_DEN_W     = 33;
    localparam int QRS_MAG_W     = 34;

    localparam logic [QRS_TMIN_W-1:0] QRS_TMIN_RESET = 31'd66;
    localparam logic                  QRS_REG_TMIN   = 1'b0;

    typedef struct packed {
        logic                  valid;
        logic                  miss;
        logic                  den_neg;
        logic                  n0_neg;
        logic                  n1_neg;
        logic signed [31:0]    b;
        logic signed [31:0]    best;
        logic [QRS_DEN_W-1:0]  den;
    } side_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_nearest;
        logic signed [31:0] root_near;
        logic signed [31:0] root_far;
    } out_t;

endpackage

// ----- rtl/qrs_if.sv -----
// item channels of the ray quadratic root select block
// no dependencies
interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] t_best;
    modport source (output valid, coef_a, coef_b, coef_c, t_best, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, t_best, output ready);
endinterface

interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] t_nearest;
    logic signed [31:0] root_near;
    logic signed [31:0] root_far;
    modport source (output valid, hit, t_nearest, root_near, root_far, input ready);
    modport sink (input valid, hit, t_nearest, root_near, root_far, output ready);
endinterface

// ----- rtl/qrs_sqrt_cell.sv -----
// one radix-2 step of the pipelined discriminant square root
// depends on qrs_pkg
module qrs_sqrt_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  qrs_pkg::side_t                   side_in,
    input  logic [qrs_pkg::QRS_DISC_W-1:0]   d_in,
    input  logic [qrs_pkg::QRS_REM_W-1:0]    rem_in,
    input  logic [qrs_pkg::QRS_ROOT_W-1:0]   root_in,
    output qrs_pkg::side_t                   side_out,
    output logic [qrs_pkg::QRS_DISC_W-1:0]   d_out,
    output logic [qrs_pkg::QRS_REM_W-1:0]    rem_out,
    output logic [qrs_pkg::QRS_ROOT_W-1:0]   root_out
);
    import qrs_pkg::*;

    side_t                 side_reg;
    logic [QRS_DISC_W-1:0] d_reg;
    logic [QRS_REM_W-1:0]  rem_reg;
    logic [QRS_ROOT_W-1:0] root_reg;
    logic [QRS_REM_W+1:0]  rem_sh;
    logic [QRS_REM_W+1:0]  trial;
    logic [QRS_REM_W+1:0]  diff;
    logic                  ge;

    assign rem_sh = {rem_in, d_in[QRS_DISC_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= {d_in[QRS_DISC_W-3:0], 2'b00};
            if (ge)
            begin
                rem_reg  <= diff[QRS_REM_W-1:0];
                root_reg <= {root_in[QRS_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[QRS_REM_W-1:0];
                root_reg <= {root_in[QRS_ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign side_out = side_reg;
    assign d_out    = d_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ----- rtl/qrs_div_cell.sv -----
// one restoring step of the two pipelined root divisions
// depends on qrs_pkg
module qrs_div_cell #(
    parameter int NW = 50
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  qrs_pkg::side_t                  side_in,
    input  logic [NW-1:0]                   num0_in,
    input  logic [NW-1:0]                   num1_in,
    input  logic [qrs_pkg::QRS_DEN_W-1:0]   rem0_in,
    input  logic [qrs_pkg::QRS_DEN_W-1:0]   rem1_in,
    input  logic [NW-1:0]                   q0_in,
    input  logic [NW-1:0]                   q1_in,
    output qrs_pkg::side_t                  side_out,
    output logic [NW-1:0]                   num0_out,
    output logic [NW-1:0]                   num1_out,
    output logic [qrs_pkg::QRS_DEN_W-1:0]   rem0_out,
    output logic [qrs_pkg::QRS_DEN_W-1:0]   rem1_out,
    output logic [NW-1:0]                   q0_out,
    output logic [NW-1:0]                   q1_out
);
    import qrs_pkg::*;

    side_t                side_reg;
    logic [NW-1:0]        num0_reg, num1_reg, q0_reg, q1_reg;
    logic [QRS_DEN_W-1:0] rem0_reg, rem1_reg;
    logic [QRS_DEN_W:0]   sh0, sh1, den_x, diff0, diff1;
    logic                 ge0, ge1;

    assign den_x = {1'b0, side_in.den};
    assign sh0   = {rem0_in, num0_in[NW-1]};
    assign sh1   = {rem1_in, num1_in[NW-1]};
    assign diff0 = sh0 - den_x;
    assign diff1 = sh1 - den_x;
    assign ge0   = (sh0 >= den_x);
    assign ge1   = (sh1 >= den_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg <= {num0_in[NW-2:0], 1'b0};
            num1_reg <= {num1_in[NW-2:0], 1'b0};
            rem0_reg <= ge0 ? diff0[QRS_DEN_W-1:0] : sh0[QRS_DEN_W-1:0];
            rem1_reg <= ge1 ? diff1[QRS_DEN_W-1:0] : sh1[QRS_DEN_W-1:0];
            q0_reg   <= {q0_in[NW-2:0], ge0};
            q1_reg   <= {q1_in[NW-2:0], ge1};
        end
    end

    assign side_out = side_reg;
    assign num0_out = num0_reg;
    assign num1_out = num1_reg;
    assign rem0_out = rem0_reg;
    assign rem1_out = rem1_reg;
    assign q0_out   = q0_reg;
    assign q1_out   = q1_reg;

endmodule

// ----- rtl/ray_quadratic_root_select_core.sv -----
// top level of the ray quadratic root select block
// depends on qrs_pkg, qrs_if, qrs_sqrt_cell and qrs_div_cell
//
// usage:
// in_ch carries one item per cycle while in_ch.ready is high: coefficients a, b, c and the nearest hit
// distance so far, all signed fixed point with FRAC_BITS fraction bits.
// out_ch returns one item per input item, in order: hit flag, updated nearest
// distance and both roots (roots zero on a miss).
// the apb port holds the minimum hit distance at byte address 0; write it only while idle.
// throughput: one item per cycle while out_ch takes items.
// pipeline: three front stages (operand magnitudes, two 32x32 products,
// discriminant), a chain of 33 square root cells, a numerator stage, a chain
// of 34 + FRAC_BITS divider cells (both roots side by side) and root select
// into the output buffer.
// the whole chain advances together; a two-entry output buffer absorbs a
// stalled receiver, and in_ch.ready drops only while that buffer is full.
// reset clears all valid flags, empties the buffer and sets the minimum hit distance to 66.
module ray_quadratic_root_select_core #(
    parameter int FRAC_BITS = qrs_pkg::QRS_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qrs_pkg::QRS_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    qrs_in_if.sink                          in_ch,
    qrs_out_if.source                       out_ch
);
    import qrs_pkg::*;

    localparam int NW = QRS_MAG_W + FRAC_BITS;

    // configuration
    logic [QRS_TMIN_W-1:0] tmin_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmin_reg <= QRS_TMIN_RESET;
        end
        else if (cfg_wr && paddr[2] == QRS_REG_TMIN)
        begin
            tmin_reg <= pwdata[QRS_TMIN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == QRS_REG_TMIN) ? {1'b0, tmin_reg} : 32'd0;

    // output buffer and chain enable
    out_t       buf_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       en, push, pop;
    out_t       fin;
    logic       fin_valid;

    assign en          = (cnt_reg != 2'd2);
    assign in_ch.ready = en;

    // stage 1: magnitudes
    logic               s1_valid_reg, s1_an_reg, s1_cn_reg, s1_azero_reg;
    logic [31:0]        s1_am_reg, s1_bm_reg, s1_cm_reg;
    logic signed [31:0] s1_b_reg, s1_best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_an_reg    <= in_ch.coef_a[31];
            s1_cn_reg    <= in_ch.coef_c[31];
            s1_azero_reg <= (in_ch.coef_a == 32'sd0);
            s1_am_reg    <= in_ch.coef_a[31] ? (~in_ch.coef_a + 32'd1) : in_ch.coef_a;
            s1_bm_reg    <= in_ch.coef_b[31] ? (~in_ch.coef_b + 32'd1) : in_ch.coef_b;
            s1_cm_reg    <= in_ch.coef_c[31] ? (~in_ch.coef_c + 32'd1) : in_ch.coef_c;
            s1_b_reg     <= in_ch.coef_b;
            s1_best_reg  <= in_ch.t_best;
        end
    end

    // stage 2: products
    logic               s2_valid_reg, s2_an_reg, s2_sdiff_reg, s2_azero_reg;
    logic [63:0]        s2_b2_reg, s2_p_reg;
    logic [31:0]        s2_am_reg;
    logic signed [31:0] s2_b_reg, s2_best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_b2_reg    <= s1_bm_reg * s1_bm_reg;
            s2_p_reg     <= s1_am_reg * s1_cm_reg;
            s2_an_reg    <= s1_an_reg;
            s2_sdiff_reg <= s1_an_reg ^ s1_cn_reg;
            s2_azero_reg <= s1_azero_reg;
            s2_am_reg    <= s1_am_reg;
            s2_b_reg     <= s1_b_reg;
            s2_best_reg  <= s1_best_reg;
        end
    end

    // stage 3: discriminant
    logic [QRS_DISC_W-1:0] p4, b2x, d_next, s3_d_reg;
    logic                  neg_disc;
    side_t                 s3_side_next, s3_side_reg;

    assign p4  = {s2_p_reg, 2'b00};
    assign b2x = {2'b00, s2_b2_reg};

    always_comb
    begin
        neg_disc = 1'b0;
        if (s2_sdiff_reg && s2_p_reg != 64'd0)
        begin
            d_next = b2x + p4;
        end
        else
        begin
            d_next   = b2x - p4;
            neg_disc = (p4 > b2x);
        end
        s3_side_next         = '0;
        s3_side_next.valid   = s2_valid_reg;
        s3_side_next.miss    = neg_disc || s2_azero_reg;
        s3_side_next.den_neg = s2_an_reg;
        s3_side_next.b       = s2_b_reg;
        s3_side_next.best    = s2_best_reg;
        s3_side_next.den     = {s2_am_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg <= '0;
        end
        else if (en)
        begin
            s3_side_reg <= s3_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_d_reg <= d_next;
        end
    end

    // square root chain
    side_t                 sq_side [QRS_ROOT_W+1];
    logic [QRS_DISC_W-1:0] sq_d    [QRS_ROOT_W+1];
    logic [QRS_REM_W-1:0]  sq_rem  [QRS_ROOT_W+1];
    logic [QRS_ROOT_W-1:0] sq_root [QRS_ROOT_W+1];

    // the top pair of the 66-bit value enters the first cell
    assign sq_side[0] = s3_side_reg;
    assign sq_d[0]    = s3_d_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < QRS_ROOT_W; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (sq_side[i]),
            .d_in     (sq_d[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_out (sq_side[i+1]),
            .d_out    (sq_d[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1])
        );
    end

    // numerator stage
    logic signed [QRS_MAG_W:0] bx, sx, n0, n1;
    logic [QRS_MAG_W-1:0]      n0m, n1m;
    side_t                     nm_side_next, nm_side_reg;
    logic [NW-1:0]             nm_num0_reg, nm_num1_reg;

    assign bx  = {{(QRS_MAG_W-31){sq_side[QRS_ROOT_W].b[31]}}, sq_side[QRS_ROOT_W].b};
    assign sx  = {2'b00, sq_root[QRS_ROOT_W]};
    assign n0  = -bx - sx;
    assign n1  = -bx + sx;
    assign n0m = n0[QRS_MAG_W] ? -n0[QRS_MAG_W-1:0] : n0[QRS_MAG_W-1:0];
    assign n1m = n1[QRS_MAG_W] ? -n1[QRS_MAG_W-1:0] : n1[QRS_MAG_W-1:0];

    always_comb
    begin
        nm_side_next        = sq_side[QRS_ROOT_W];
        nm_side_next.n0_neg = n0[QRS_MAG_W];
        nm_side_next.n1_neg = n1[QRS_MAG_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_side_reg <= '0;
        end
        else if (en)
        begin
            nm_side_reg <= nm_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_num0_reg <= {n0m, {FRAC_BITS{1'b0}}};
            nm_num1_reg <= {n1m, {FRAC_BITS{1'b0}}};
        end
    end

    // divider chain
    side_t                dv_side [NW+1];
    logic [NW-1:0]        dv_num0 [NW+1];
    logic [NW-1:0]        dv_num1 [NW+1];
    logic [QRS_DEN_W-1:0] dv_rem0 [NW+1];
    logic [QRS_DEN_W-1:0] dv_rem1 [NW+1];
    logic [NW-1:0]        dv_q0   [NW+1];
    logic [NW-1:0]        dv_q1   [NW+1];

    assign dv_side[0] = nm_side_reg;
    assign dv_num0[0] = nm_num0_reg;
    assign dv_num1[0] = nm_num1_reg;
    assign dv_rem0[0] = '0;
    assign dv_rem1[0] = '0;
    assign dv_q0[0]   = '0;
    assign dv_q1[0]   = '0;

    for (genvar j = 0; j < NW; j++)
    begin : g_div
        qrs_div_cell #(.NW(NW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (dv_side[j]),
            .num0_in  (dv_num0[j]),
            .num1_in  (dv_num1[j]),
            .rem0_in  (dv_rem0[j]),
            .rem1_in  (dv_rem1[j]),
            .q0_in    (dv_q0[j]),
            .q1_in    (dv_q1[j]),
            .side_out (dv_side[j+1]),
            .num0_out (dv_num0[j+1]),
            .num1_out (dv_num1[j+1]),
            .rem0_out (dv_rem0[j+1]),
            .rem1_out (dv_rem1[j+1]),
            .q0_out   (dv_q0[j+1]),
            .q1_out   (dv_q1[j+1])
        );
    end

    // saturation and root select
    side_t              fs;
    logic [NW-1:0]      q0, q1;
    logic signed [31:0] t0, t1, tmin_s;
    logic               neg0, neg1, take0, take1;

    assign fs     = dv_side[NW];
    assign q0     = dv_q0[NW];
    assign q1     = dv_q1[NW];
    assign neg0   = fs.n0_neg != fs.den_neg;
    assign neg1   = fs.n1_neg != fs.den_neg;
    assign tmin_s = {1'b0, tmin_reg};

    always_comb
    begin
        if (neg0)
        begin
            t0 = ((|q0[NW-1:32]) || (q0[31] && (|q0[30:0]))) ?
                 32'sh8000_0000 : -q0[31:0];
        end
        else
        begin
            t0 = (|q0[NW-1:31]) ? 32'sh7fff_ffff : q0[31:0];
        end
        if (neg1)
        begin
            t1 = ((|q1[NW-1:32]) || (q1[31] && (|q1[30:0]))) ?
                 32'sh8000_0000 : -q1[31:0];
        end
        else
        begin
            t1 = (|q1[NW-1:31]) ? 32'sh7fff_ffff : q1[31:0];
        end
        take0 = (t0 > tmin_s) && (t0 < fs.best) && (t0 < t1);
        take1 = (t1 > tmin_s) && (t1 < fs.best);
        fin   = '0;
        fin.t_nearest = fs.best;
        if (!fs.miss && (take0 || take1))
        begin
            fin.hit       = 1'b1;
            fin.t_nearest = take0 ? t0 : t1;
            fin.root_near = t0;
            fin.root_far  = t1;
        end
    end

    assign fin_valid = fs.valid;
    assign push      = en && fin_valid;
    assign pop       = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= fin;
        end
    end

    assign out_ch.valid     = (cnt_reg != 2'd0);
    assign out_ch.hit       = buf_mem[rd_ptr_reg].hit;
    assign out_ch.t_nearest = buf_mem[rd_ptr_reg].t_nearest;
    assign out_ch.root_near = buf_mem[rd_ptr_reg].root_near;
    assign out_ch.root_far  = buf_mem[rd_ptr_reg].root_far;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("output buffer pointers disagree with count");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.hit) |-> (out_ch.root_near == 32'sd0 &&
        out_ch.root_far == 32'sd0))
        else $error("roots not zero on a miss");

    a_hit_root: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.hit) |-> (out_ch.t_nearest == out_ch.root_near ||
        out_ch.t_nearest == out_ch.root_far))
        else $error("nearest distance is not one of the roots");

endmodule
